// File: rtl/core/swfs_pkg.sv
// ----------------------------------------------------------------------------
// swfs_pkg: shared types and constants of the stop-and-wait frame sender
// Operation and event codes, frame bytes, queue entry and result types.
// ----------------------------------------------------------------------------
package swfs_pkg;

    localparam int MaxPayload = 256;
    localparam int PayAw      = $clog2(MaxPayload);
    localparam int PayCw      = $clog2(MaxPayload + 1);
    localparam int IdxW       = PayCw + 1;

    localparam logic [2:0] OP_OPEN  = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_TICK  = 3'd3;
    localparam logic [2:0] OP_PULL  = 3'd4;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_LINK_UP    = 3'd1;
    localparam logic [2:0] EV_LINK_FAIL  = 3'd2;
    localparam logic [2:0] EV_ACKED      = 3'd3;
    localparam logic [2:0] EV_REJ_RETRY  = 3'd4;
    localparam logic [2:0] EV_TO_RETRY   = 3'd5;
    localparam logic [2:0] EV_FRAME_FAIL = 3'd6;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ADDR_TX   = 8'h03;
    localparam logic [7:0] ADDR_RX   = 8'h01;
    localparam logic [7:0] CTL_SET   = 8'h03;
    localparam logic [7:0] CTL_UA    = 8'h07;
    localparam logic [7:0] CTL_I0    = 8'h00;
    localparam logic [7:0] CTL_I1    = 8'h40;
    localparam logic [7:0] CTL_RR0   = 8'h05;
    localparam logic [7:0] CTL_RR1   = 8'h85;
    localparam logic [7:0] CTL_REJ0  = 8'h01;
    localparam logic [7:0] CTL_REJ1  = 8'h81;

    // Classified item passed from the front end to the engine
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       fin;
        logic       seq;
    } swfs_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_frame_end;
        logic [2:0] event_res;
    } swfs_res_t;

endpackage

// File: rtl/core/stop_and_wait_frame_sender_unit.sv
// ----------------------------------------------------------------------------
// stop_and_wait_frame_sender_unit: stop-and-wait framed link sender
// Opens the link, frames payload into I frames and handles replies.
// ----------------------------------------------------------------------------
// Usage: each item on the s_axis channel is an operation in tuser (open,
// payload byte, received line byte, tick or transmit pull) with its byte in
// tdata; each gives exactly one result on m_axis: the pulled frame byte when
// there is one, tlast on the closing flag, and an event code in tuser.
// Configuration writes on the cfg channel (index 0 retry limit, 1 timeout
// ticks) are taken at any time and must only be issued while the block is idle.
// Path: an accepted item is written into the input queue; the engine takes
// it from there when its output slot is free or being taken, and loads its
// output register, which offers the result on m_axis.
// Throughput: one item per cycle while the receiver takes each result; the
// engine updates all link state as it takes an item, and the payload byte
// for the next pull is read from the payload memory one pull ahead. Reset
// puts the link in idle with an empty payload, retry limit 3 and timeout 3;
// no clearing pass is needed. When the receiver stalls, the result is held
// and the two-entry input queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_sender_unit
    import swfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // data_byte[7:0], sequence_req[8]
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    input  logic        s_axis_tlast,  // final_payload
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // tx_valid[0], tx_byte[8:1]
    output logic [2:0]  m_axis_tuser,  // event_res[2:0]
    output logic        m_axis_tlast,  // tx_frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    swfs_item_t in_item;
    swfs_item_t q_item;
    swfs_res_t  res;
    logic       q_valid;
    logic       q_ready;
    logic [2:0] retry_limit_reg;
    logic [7:0] timeout_ticks_reg;

    assign in_item.op   = s_axis_tuser;
    assign in_item.data = s_axis_tdata[7:0];
    assign in_item.seq  = s_axis_tdata[8];
    assign in_item.fin  = s_axis_tlast;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= 3'd3;
            timeout_ticks_reg <= 8'd3;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'b0)
                retry_limit_reg <= cfg_data[2:0];
            else
                timeout_ticks_reg <= cfg_data;
        end
    end

    swfs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    swfs_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .retry_limit   (retry_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res           (res)
    );

    assign m_axis_tdata = {7'd0, res.tx_byte, res.tx_valid};
    assign m_axis_tuser = res.event_res;
    assign m_axis_tlast = res.tx_frame_end;

endmodule

// File: rtl/core/swfs_front.sv
// ----------------------------------------------------------------------------
// swfs_front: input stage and item queue
// Registers items from the input stream in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module swfs_front
    import swfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  swfs_item_t in_item,
    output logic       q_valid,
    input  logic       q_ready,
    output swfs_item_t q_item
);

    swfs_item_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

endmodule

// File: rtl/core/swfs_engine.sv
// ----------------------------------------------------------------------------
// swfs_engine: link and frame engine
// Runs the link phases, the reply parser, retries and frame output.
// ----------------------------------------------------------------------------
module swfs_engine
    import swfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  swfs_item_t q_item,
    input  logic [2:0] retry_limit,
    input  logic [7:0] timeout_ticks,
    output logic       res_valid,
    input  logic       res_ready,
    output swfs_res_t  res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_OPEN_SEND, PH_OPEN_WAIT, PH_UP, PH_DATA_SEND, PH_DATA_WAIT
    } phase_t;

    typedef enum logic [2:0] {
        RP_START, RP_FLAG, RP_ADDR, RP_CTRL, RP_BCC
    } parse_t;

    logic [7:0]      store_mem [MaxPayload];
    phase_t          phase_reg, phase_next;
    parse_t          parse_reg, parse_next;
    logic [7:0]      raddr_reg, raddr_next;
    logic [7:0]      rctl_reg, rctl_next;
    logic [PayCw-1:0] count_reg, count_next;
    logic [7:0]      par_reg, par_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [2:0]      att_reg, att_next;
    logic [7:0]      tmr_reg, tmr_next;
    logic            seq_reg, seq_next;
    logic            ov_reg;
    swfs_res_t       out_reg, out_next;
    logic [7:0]      rd_reg;
    logic            rd_sel_reg;

    // Output slot: filled whenever an item is taken; a pending result blocks intake unless the receiver is ready
    logic            go;
    logic            wr_en;
    logic [PayAw-1:0] rd_addr;
    logic [IdxW-1:0] idx_cur;

    assign q_ready   = !ov_reg || res_ready;
    assign go        = q_valid && q_ready;
    assign res_valid = ov_reg;

    // Payload byte read one pull ahead: the address is the index after this pull
    logic [IdxW-1:0] pre_idx;
    assign idx_cur = idx_reg;

    always_comb
    begin
        logic       waiting;
        logic       opening;
        logic [7:0] addr_exp;
        logic       ctlok;
        logic [7:0] ctl_i;
        logic [2:0] lim;
        logic [7:0] tlim;
        logic [2:0] ev;
        logic [7:0] tb;
        logic       last;
        logic [IdxW-1:0] pc;
        logic       fail;

        phase_next = phase_reg;
        parse_next = parse_reg;
        raddr_next = raddr_reg;
        rctl_next  = rctl_reg;
        count_next = count_reg;
        par_next   = par_reg;
        idx_next   = idx_reg;
        att_next   = att_reg;
        tmr_next   = tmr_reg;
        seq_next   = seq_reg;
        wr_en      = 1'b0;
        out_next   = '0;
        ev         = EV_NONE;
        tb         = 8'h00;
        last       = 1'b0;
        fail       = 1'b0;

        waiting  = (phase_reg == PH_OPEN_WAIT) || (phase_reg == PH_DATA_WAIT);
        opening  = (phase_reg == PH_OPEN_WAIT);
        addr_exp = opening ? ADDR_RX : ADDR_TX;
        ctlok    = opening ? (q_item.data == CTL_UA)
                           : (q_item.data == CTL_RR0 || q_item.data == CTL_RR1 ||
                              q_item.data == CTL_REJ0 || q_item.data == CTL_REJ1);
        ctl_i    = seq_reg ? CTL_I1 : CTL_I0;
        lim      = (retry_limit == 3'd0) ? 3'd1 : retry_limit;
        tlim     = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
        pc       = IdxW'(count_reg);

        case (q_item.op)
            OP_OPEN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    att_next   = 3'd0;
                    phase_next = PH_OPEN_SEND;
                    idx_next   = '0;
                    parse_next = RP_START;
                    tmr_next   = 8'd0;
                end
            end
            OP_DATA:
            begin
                if (phase_reg == PH_UP)
                begin
                    if (count_reg < PayCw'(MaxPayload))
                    begin
                        wr_en      = 1'b1;
                        par_next   = par_reg ^ q_item.data;
                        count_next = count_reg + 1'b1;
                    end
                    if (q_item.fin)
                    begin
                        seq_next   = q_item.seq;
                        att_next   = 3'd0;
                        phase_next = PH_DATA_SEND;
                        idx_next   = '0;
                        parse_next = RP_START;
                        tmr_next   = 8'd0;
                    end
                end
            end
            OP_LINE:
            begin
                if (waiting)
                begin
                    case (parse_reg)
                        RP_START:
                            if (q_item.data == FLAG_BYTE)
                                parse_next = RP_FLAG;
                        RP_FLAG:
                        begin
                            if (q_item.data == addr_exp)
                            begin
                                raddr_next = q_item.data;
                                parse_next = RP_ADDR;
                            end
                            else if (q_item.data != FLAG_BYTE)
                                parse_next = RP_START;
                        end
                        RP_ADDR:
                        begin
                            if (ctlok)
                            begin
                                rctl_next  = q_item.data;
                                parse_next = RP_CTRL;
                            end
                            else
                                parse_next = (q_item.data == FLAG_BYTE) ? RP_FLAG : RP_START;
                        end
                        RP_CTRL:
                        begin
                            if (q_item.data == (raddr_reg ^ rctl_reg))
                                parse_next = RP_BCC;
                            else
                                parse_next = (q_item.data == FLAG_BYTE) ? RP_FLAG : RP_START;
                        end
                        default:
                        begin
                            parse_next = RP_START;
                            if (q_item.data == FLAG_BYTE)
                            begin
                                if (opening)
                                begin
                                    phase_next = PH_UP;
                                    count_next = '0;
                                    par_next   = 8'd0;
                                    tmr_next   = 8'd0;
                                    ev         = EV_LINK_UP;
                                end
                                else if (rctl_reg == (seq_reg ? CTL_RR1 : CTL_RR0))
                                begin
                                    phase_next = PH_UP;
                                    count_next = '0;
                                    par_next   = 8'd0;
                                    tmr_next   = 8'd0;
                                    ev         = EV_ACKED;
                                end
                                else
                                begin
                                    fail = 1'b1;
                                    ev   = EV_REJ_RETRY;
                                end
                            end
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (waiting)
                begin
                    if (tmr_reg != 8'hFF)
                        tmr_next = tmr_reg + 8'd1;
                    if (tmr_next >= tlim)
                    begin
                        fail = 1'b1;
                        ev   = EV_TO_RETRY;
                    end
                end
            end
            OP_PULL:
            begin
                if (phase_reg == PH_OPEN_SEND)
                begin
                    last = (idx_reg >= IdxW'(4));
                    case (idx_reg[2:0])
                        3'd1:    tb = ADDR_TX;
                        3'd2:    tb = CTL_SET;
                        3'd3:    tb = ADDR_TX ^ CTL_SET;
                        default: tb = FLAG_BYTE;
                    endcase
                    if (idx_reg > IdxW'(4))
                        tb = FLAG_BYTE;
                end
                else if (phase_reg == PH_DATA_SEND)
                begin
                    last = (idx_reg >= pc + IdxW'(5));
                    if (idx_reg == IdxW'(0))
                        tb = FLAG_BYTE;
                    else if (idx_reg == IdxW'(1))
                        tb = ADDR_TX;
                    else if (idx_reg == IdxW'(2))
                        tb = ctl_i;
                    else if (idx_reg == IdxW'(3))
                        tb = ADDR_TX ^ ctl_i;
                    else if (idx_reg < pc + IdxW'(4))
                        tb = rd_sel_reg ? rd_reg : 8'h00;
                    else if (idx_reg == pc + IdxW'(4))
                        tb = par_reg;
                    else
                        tb = FLAG_BYTE;
                end
                if (phase_reg == PH_OPEN_SEND || phase_reg == PH_DATA_SEND)
                begin
                    out_next.tx_valid = 1'b1;
                    if (last)
                    begin
                        out_next.tx_frame_end = 1'b1;
                        phase_next = (phase_reg == PH_OPEN_SEND) ? PH_OPEN_WAIT
                                                                 : PH_DATA_WAIT;
                        parse_next = RP_START;
                        tmr_next   = 8'd0;
                        idx_next   = '0;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Attempt failed: retry or give up
        if (fail)
        begin
            att_next = att_reg + 3'd1;
            if (att_next >= lim || att_next == 3'd0)
            begin
                parse_next = RP_START;
                tmr_next   = 8'd0;
                if (opening)
                begin
                    phase_next = PH_IDLE;
                    ev         = EV_LINK_FAIL;
                end
                else
                begin
                    phase_next = PH_UP;
                    count_next = '0;
                    par_next   = 8'd0;
                    ev         = EV_FRAME_FAIL;
                end
            end
            else
            begin
                phase_next = opening ? PH_OPEN_SEND : PH_DATA_SEND;
                idx_next   = '0;
                parse_next = RP_START;
                tmr_next   = 8'd0;
            end
        end

        out_next.tx_byte   = tb;
        out_next.event_res = ev;
    end

    // Prefetch the payload byte for the next send index
    always_comb
    begin
        pre_idx = go ? idx_next : idx_cur;
        if (pre_idx >= IdxW'(4))
            rd_addr = PayAw'(pre_idx - IdxW'(4));
        else
            rd_addr = '0;
    end

    always_ff @(posedge clk)
    begin
        if (go && wr_en)
            store_mem[PayAw'(count_reg)] <= q_item.data;
        rd_reg <= store_mem[rd_addr];
    end

    // Collision flag: a byte written in this cycle at the prefetched address is not passed through; it reads as 00
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_sel_reg <= 1'b0;
        else
            rd_sel_reg <= !(go && wr_en && (PayAw'(count_reg) == rd_addr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            parse_reg <= RP_START;
            raddr_reg <= 8'd0;
            rctl_reg  <= 8'd0;
            count_reg <= '0;
            par_reg   <= 8'd0;
            idx_reg   <= '0;
            att_reg   <= 3'd0;
            tmr_reg   <= 8'd0;
            seq_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            if (go)
            begin
                phase_reg <= phase_next;
                parse_reg <= parse_next;
                raddr_reg <= raddr_next;
                rctl_reg  <= rctl_next;
                count_reg <= count_next;
                par_reg   <= par_next;
                idx_reg   <= idx_next;
                att_reg   <= att_next;
                tmr_reg   <= tmr_next;
                seq_reg   <= seq_next;
                out_reg   <= out_next;
                ov_reg    <= 1'b1;
            end
            else if (res_ready)
                ov_reg <= 1'b0;
        end
    end

    assign res = out_reg;

endmodule

// File: test/stop_and_wait_frame_sender_unit_tb.sv
// ----------------------------------------------------------------------------
// stop_and_wait_frame_sender_unit_tb: self-checking bench for the frame sender
// Drives operations on s_axis under random gaps and back-pressure, predicts
// every result with a cycle-free model of the link and compares each m_axis
// transfer field by field. Retry limit and timeout are changed between phases.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_sender_unit_tb;
    import swfs_pkg::*;

    typedef enum logic [2:0] {
        LK_IDLE, LK_OPEN_SEND, LK_OPEN_WAIT, LK_UP, LK_DATA_SEND, LK_DATA_WAIT
    } link_phase_e;

    typedef enum logic [2:0] {
        RX_START, RX_FLAG, RX_ADDR, RX_CTRL, RX_BCC
    } reply_state_e;

    localparam logic CFG_RETRY   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    class frame_sender_scoreboard;
        logic [2:0]   retry_lim;
        logic [7:0]   timeout_lim;
        logic [7:0]   pay_mem [MaxPayload];
        int unsigned  pay_count;
        logic [7:0]   pay_xor;
        link_phase_e  phase;
        reply_state_e rx_state;
        logic [7:0]   rx_addr;
        logic [7:0]   rx_ctl;
        int unsigned  send_idx;
        logic [2:0]   attempts;
        logic [7:0]   timer;
        logic         cur_seq;
        swfs_res_t    pending [$];
        int           errors;
        int           checked;
        int           ev_seen [8];

        function new();
            retry_lim   = 3;
            timeout_lim = 3;
            pay_count   = 0;
            pay_xor     = 0;
            phase       = LK_IDLE;
            rx_state    = RX_START;
            rx_addr     = 0;
            rx_ctl      = 0;
            send_idx    = 0;
            attempts    = 0;
            timer       = 0;
            cur_seq     = 0;
            errors      = 0;
            checked     = 0;
            foreach (ev_seen[i]) ev_seen[i] = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void set_config(logic idx, logic [7:0] val);
            if (idx == CFG_RETRY) retry_lim = val[2:0];
            else timeout_lim = val;
        endfunction

        function void new_attempt(link_phase_e ph);
            phase    = ph;
            send_idx = 0;
            rx_state = RX_START;
            timer    = 0;
        endfunction

        function logic [2:0] retry_or_fail(logic [2:0] retry_ev);
            logic [2:0] lim;
            logic       opening;
            lim      = (retry_lim == 0) ? 3'd1 : retry_lim;
            attempts = attempts + 3'd1;
            opening  = (phase == LK_OPEN_WAIT);
            if (attempts >= lim || attempts == 0) begin
                rx_state = RX_START;
                timer    = 0;
                if (opening) begin
                    phase = LK_IDLE;
                    return EV_LINK_FAIL;
                end
                phase     = LK_UP;
                pay_count = 0;
                pay_xor   = 0;
                return EV_FRAME_FAIL;
            end
            new_attempt(opening ? LK_OPEN_SEND : LK_DATA_SEND);
            return retry_ev;
        endfunction

        function logic [2:0] parse_line(logic [7:0] b);
            logic       opening;
            logic [7:0] addr;
            logic       ctl_good;
            opening  = (phase == LK_OPEN_WAIT);
            addr     = opening ? ADDR_RX : ADDR_TX;
            ctl_good = opening ? (b == CTL_UA)
                     : (b == CTL_RR0 || b == CTL_RR1 || b == CTL_REJ0 || b == CTL_REJ1);
            case (rx_state)
                RX_START: if (b == FLAG_BYTE) rx_state = RX_FLAG;
                RX_FLAG: begin
                    if (b == addr) begin
                        rx_addr  = b;
                        rx_state = RX_ADDR;
                    end else if (b != FLAG_BYTE) rx_state = RX_START;
                end
                RX_ADDR: begin
                    if (ctl_good) begin
                        rx_ctl   = b;
                        rx_state = RX_CTRL;
                    end else rx_state = (b == FLAG_BYTE) ? RX_FLAG : RX_START;
                end
                RX_CTRL: begin
                    if (b == (rx_addr ^ rx_ctl)) rx_state = RX_BCC;
                    else rx_state = (b == FLAG_BYTE) ? RX_FLAG : RX_START;
                end
                default: begin
                    rx_state = RX_START;
                    if (b != FLAG_BYTE) return EV_NONE;
                    if (opening || rx_ctl == (cur_seq ? CTL_RR1 : CTL_RR0)) begin
                        phase     = LK_UP;
                        pay_count = 0;
                        pay_xor   = 0;
                        timer     = 0;
                        return opening ? EV_LINK_UP : EV_ACKED;
                    end
                    return retry_or_fail(EV_REJ_RETRY);
                end
            endcase
            return EV_NONE;
        endfunction

        // Work out the byte at the current send position; flags the closing one
        function logic [7:0] next_tx_byte(output logic last);
            logic [7:0] ctl;
            if (phase == LK_OPEN_SEND) begin
                last = (send_idx >= 4);
                case (send_idx)
                    0:       return FLAG_BYTE;
                    1:       return ADDR_TX;
                    2:       return CTL_SET;
                    3:       return ADDR_TX ^ CTL_SET;
                    default: return FLAG_BYTE;
                endcase
            end
            ctl  = cur_seq ? CTL_I1 : CTL_I0;
            last = (send_idx >= pay_count + 5);
            if (send_idx == 0) return FLAG_BYTE;
            if (send_idx == 1) return ADDR_TX;
            if (send_idx == 2) return ctl;
            if (send_idx == 3) return ADDR_TX ^ ctl;
            if (send_idx < pay_count + 4) return pay_mem[(send_idx - 4) % MaxPayload];
            if (send_idx == pay_count + 4) return pay_xor;
            return FLAG_BYTE;
        endfunction

        function void note_item(logic [2:0] op, logic [7:0] b, logic fin, logic seq);
            swfs_res_t r;
            logic      waiting;
            logic      last;
            logic [7:0] lim;
            r       = '0;
            waiting = (phase == LK_OPEN_WAIT || phase == LK_DATA_WAIT);
            case (op)
                OP_OPEN: if (phase == LK_IDLE) begin
                    attempts = 0;
                    new_attempt(LK_OPEN_SEND);
                end
                OP_DATA: if (phase == LK_UP) begin
                    if (pay_count < MaxPayload) begin
                        pay_mem[pay_count] = b;
                        pay_xor ^= b;
                        pay_count++;
                    end
                    if (fin) begin
                        cur_seq  = seq;
                        attempts = 0;
                        new_attempt(LK_DATA_SEND);
                    end
                end
                OP_LINE: if (waiting) r.event_res = parse_line(b);
                OP_TICK: if (waiting) begin
                    lim = (timeout_lim == 0) ? 8'd1 : timeout_lim;
                    if (timer < 8'hFF) timer++;
                    if (timer >= lim) r.event_res = retry_or_fail(EV_TO_RETRY);
                end
                OP_PULL: if (phase == LK_OPEN_SEND || phase == LK_DATA_SEND) begin
                    r.tx_byte  = next_tx_byte(last);
                    r.tx_valid = 1'b1;
                    if (last) begin
                        r.tx_frame_end = 1'b1;
                        phase    = (phase == LK_OPEN_SEND) ? LK_OPEN_WAIT : LK_DATA_WAIT;
                        rx_state = RX_START;
                        timer    = 0;
                        send_idx = 0;
                    end else send_idx++;
                end
                default: ;
            endcase
            ev_seen[r.event_res]++;
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] data, logic [2:0] user, logic last);
            swfs_res_t e;
            if (pending.size() == 0) begin
                report($sformatf("result %h/%h with nothing expected", data, user));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (data[0] !== e.tx_valid)
                report($sformatf("tx_valid %b, expected %b", data[0], e.tx_valid));
            if (data[8:1] !== e.tx_byte)
                report($sformatf("tx_byte %h, expected %h", data[8:1], e.tx_byte));
            if (last !== e.tx_frame_end)
                report($sformatf("tx_frame_end %b, expected %b", last, e.tx_frame_end));
            if (user !== e.event_res)
                report($sformatf("event %0d, expected %0d", user, e.event_res));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;

    frame_sender_scoreboard sb = new();
    bit  no_idle = 0;
    int  hold_cycles = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    int  cfg_writes = 0;

    stop_and_wait_frame_sender_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure; a pending hold-off wins over random stalls
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else if (no_idle) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) >= 38);
    end

    always @(posedge clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Entered and left at a falling edge
    task automatic send_item(logic [2:0] op, logic [7:0] b, logic fin, logic seq);
        if (!no_idle && $urandom_range(0, 99) < 38) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, seq, b};
        s_axis_tuser  <= op;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(op, b, fin, seq);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_reply(logic [7:0] addr, logic [7:0] ctl, logic [7:0] bcc_flip);
        send_item(OP_LINE, FLAG_BYTE, 0, 0);
        send_item(OP_LINE, addr, 0, 0);
        send_item(OP_LINE, ctl, 0, 0);
        send_item(OP_LINE, addr ^ ctl ^ bcc_flip, 0, 0);
        send_item(OP_LINE, FLAG_BYTE, 0, 0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_config(idx, val);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pull_frame();
        while (sb.phase == LK_OPEN_SEND || sb.phase == LK_DATA_SEND)
            send_item(OP_PULL, 8'($urandom), 0, 0);
    endtask

    // One step of traffic chosen from the link's current phase, with some random noise items
    task automatic random_step();
        int         k;
        int         n;
        logic [7:0] ctl;
        if ($urandom_range(0, 99) < 12) begin
            send_noise();
            return;
        end
        case (sb.phase)
            LK_IDLE: send_item(OP_OPEN, 8'($urandom), 1'($urandom), 1'($urandom));
            LK_OPEN_SEND, LK_DATA_SEND: send_item(OP_PULL, 8'($urandom), 0, 1'($urandom));
            LK_UP: begin
                n = ($urandom_range(0, 99) < 2) ? $urandom_range(250, 262)
                                                : $urandom_range(1, 10);
                for (int i = 1; i < n; i++) send_item(OP_DATA, 8'($urandom), 0, 1'($urandom));
                send_item(OP_DATA, 8'($urandom), 1, 1'($urandom));
            end
            default: begin
                k = $urandom_range(0, 9);
                if (sb.phase == LK_OPEN_WAIT) begin
                    if (k < 5) send_reply(ADDR_RX, CTL_UA, 0);
                    else if (k < 7) repeat ($urandom_range(1, 4)) send_item(OP_TICK, 0, 0, 0);
                    else if (k == 7) send_reply(ADDR_RX, CTL_UA, 8'($urandom_range(1, 255)));
                    else send_item(OP_LINE, 8'($urandom), 0, 0);
                end else begin
                    ctl = sb.cur_seq ? CTL_RR1 : CTL_RR0;
                    if (k < 4) send_reply(ADDR_TX, ctl, 0);
                    else if (k == 4) send_reply(ADDR_TX, $urandom_range(0, 1) ? CTL_REJ1
                                                                        : CTL_REJ0, 0);
                    else if (k == 5) send_reply(ADDR_TX, ctl ^ 8'h80, 0);
                    else if (k == 6) repeat ($urandom_range(1, 4)) send_item(OP_TICK, 0, 0, 0);
                    else if (k == 7) send_reply(ADDR_TX, ctl, 8'($urandom_range(1, 255)));
                    else send_item(OP_LINE, 8'($urandom), 0, 0);
                end
            end
        endcase
    endtask

    initial begin
        logic [2:0] retry_set [4] = '{3'd1, 3'd7, 3'd0, 3'd2};
        logic [7:0] tmo_set   [4] = '{8'd1, 8'd255, 8'd0, 8'd4};
        int phase_no;
        int wait_cnt;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Wrong-phase and unknown operations, open, stray flags and a good UA, then one I frame
        send_item(OP_PULL, 8'h00, 0, 0);
        send_item(OP_LINE, 8'h7E, 0, 0);
        send_item(OP_TICK, 8'hFF, 1, 1);
        send_item(OP_DATA, 8'hFF, 1, 1);
        send_item(3'd5, 8'h55, 1, 0);
        send_item(3'd6, 8'hAA, 0, 1);
        send_item(3'd7, 8'hFF, 1, 1);
        send_item(OP_OPEN, 8'h00, 0, 0);
        pull_frame();
        send_item(OP_LINE, FLAG_BYTE, 0, 0);
        send_item(OP_LINE, FLAG_BYTE, 0, 0);
        send_reply(ADDR_RX, CTL_UA, 0);
        send_item(OP_OPEN, 8'h00, 0, 0);
        send_item(OP_DATA, 8'h00, 0, 0);
        send_item(OP_DATA, 8'hFF, 1, 1);
        pull_frame();
        send_reply(ADDR_TX, CTL_REJ1, 0);
        pull_frame();
        repeat (3) send_item(OP_TICK, 0, 0, 0);
        pull_frame();
        send_reply(ADDR_TX, CTL_RR1, 0);
        drain();

        phase_no = 0;
        while (items_sent < 1150) begin
            if (items_sent >= 150 * (phase_no + 1)) begin
                drain();
                if (phase_no < 4) begin
                    write_cfg(CFG_RETRY, 8'(retry_set[phase_no]));
                    write_cfg(CFG_TIMEOUT, tmo_set[phase_no]);
                end else begin
                    write_cfg(CFG_RETRY, 8'($urandom_range(0, 7)));
                    write_cfg(CFG_TIMEOUT, 8'($urandom_range(1, 6)));
                end
                phase_no++;
                no_idle = (phase_no == 3);
                if (phase_no == 2) hold_cycles = 150;
            end
            random_step();
        end
        drain();

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 2000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending.size() != 0) sb.report($sformatf("%0d results never arrived",
                                                        sb.pending.size()));
        $display("Sent %0d items, checked %0d results, %0d register writes",
                 items_sent, sb.checked, cfg_writes);
        $display("Events: link up %0d, link failed %0d, acked %0d, rej %0d, timeout %0d, fail %0d",
                 sb.ev_seen[EV_LINK_UP], sb.ev_seen[EV_LINK_FAIL], sb.ev_seen[EV_ACKED],
                 sb.ev_seen[EV_REJ_RETRY], sb.ev_seen[EV_TO_RETRY], sb.ev_seen[EV_FRAME_FAIL]);
        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/swfs_pkg.sv
rtl/core/swfs_front.sv
rtl/core/swfs_engine.sv
rtl/core/stop_and_wait_frame_sender_unit.sv
test/stop_and_wait_frame_sender_unit_tb.sv
